>>> design/ltpc_pkg.sv
// ----------------------------------------------------------------------------
// ltpc_pkg
// Shared types, command codes and constants for the led timed pattern
// controller.
// ----------------------------------------------------------------------------
package ltpc_pkg;

  localparam int unsigned LED_W   = 3;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIGHT_W = 8;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned TOG_W   = CNT_W + 1;

  // led numbers as they arrive on the light field
  localparam logic [LIGHT_W-1:0] LIGHT_LED1 = 8'd1;
  localparam logic [LIGHT_W-1:0] LIGHT_LED2 = 8'd2;
  localparam logic [LIGHT_W-1:0] LIGHT_LED3 = 8'd3;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_HIT        = 3'd1,
    CMD_BLINK      = 3'd2,
    CMD_STOP_BLINK = 3'd3,
    CMD_ALT        = 3'd4,
    CMD_STOP_ALT   = 3'd5,
    CMD_ON         = 3'd6,
    CMD_OFF        = 3'd7
  } ltpc_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]  now;
    logic [LED_W-1:0]   leds;
    logic               hit_active;
    logic [TIME_W-1:0]  hit_deadline;
    logic               blink_active;
    logic [LIGHT_W-1:0] blink_light;
    logic [TIME_W-1:0]  blink_period;
    logic [TOG_W-1:0]   toggles_left;
    logic [TIME_W-1:0]  last_event;
    logic               alt_active;
    logic [TIME_W-1:0]  alt_period;
    logic               alt_next_is_second;
  } ltpc_state_t;

  // one-hot led select, zero for numbers outside 1 to 3
  function automatic logic [LED_W-1:0] led_mask(input logic [LIGHT_W-1:0] light);
    logic [LED_W-1:0] m;
    case (light)
      LIGHT_LED1: m = 3'b001;
      LIGHT_LED2: m = 3'b010;
      LIGHT_LED3: m = 3'b100;
      default:    m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

>>> design/ltpc_if.sv
// ----------------------------------------------------------------------------
// ltpc_if
// Valid/ready channels of the led timed pattern controller: command beats in,
// led status beats out.
// ----------------------------------------------------------------------------
interface ltpc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  light;
  logic [31:0] duration;
  logic [14:0] blink_count;

  modport source (output valid, output cmd, output light, output duration,
                  output blink_count, input ready);
  modport sink   (input valid, input cmd, input light, input duration,
                  input blink_count, output ready);
endinterface

interface ltpc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] leds;
  logic       blink_busy;
  logic       alternate_busy;
  logic       hit_busy;

  modport source (output valid, output leds, output blink_busy,
                  output alternate_busy, output hit_busy, input ready);
  modport sink   (input valid, input leds, input blink_busy,
                  input alternate_busy, input hit_busy, output ready);
endinterface

>>> design/ltpc_step.sv
// ----------------------------------------------------------------------------
// ltpc_step
// Next-state logic for one command beat: tick checks (hit expiry, blink,
// alternate) and the plain led commands.
// ----------------------------------------------------------------------------
module ltpc_step import ltpc_pkg::*; (
  input  ltpc_state_t         cur,
  input  ltpc_cmd_t           cmd,
  input  logic [LIGHT_W-1:0]  light,
  input  logic [TIME_W-1:0]   duration,
  input  logic [CNT_W-1:0]    blink_count,
  output ltpc_state_t         nxt
);

  logic [LED_W-1:0]  sel_mask;
  logic [LED_W-1:0]  blink_mask;
  logic [TIME_W-1:0] now_inc;
  logic [TIME_W-1:0] blink_elapsed;
  logic [TIME_W-1:0] alt_elapsed;
  logic              blink_fire;

  assign sel_mask      = led_mask(light);
  assign blink_mask    = led_mask(cur.blink_light);
  assign now_inc       = cur.now + 1'b1;
  assign blink_elapsed = now_inc - cur.last_event;
  assign blink_fire    = cur.blink_active && (blink_elapsed >= cur.blink_period) &&
                         (blink_mask != '0);
  // a blink step moves last_event to the new time, leaving zero elapsed
  assign alt_elapsed   = blink_fire ? '0 : blink_elapsed;

  always_comb begin
    nxt = cur;
    unique case (cmd)
      CMD_TICK: begin
        nxt.now = now_inc;
        if (cur.hit_active && (now_inc > cur.hit_deadline)) begin
          nxt.leds       = '0;
          nxt.hit_active = 1'b0;
        end
        if (blink_fire) begin
          nxt.leds       = nxt.leds ^ blink_mask;
          nxt.last_event = now_inc;
          if (cur.toggles_left != '0) begin
            nxt.toggles_left = cur.toggles_left - 1'b1;
            if (cur.toggles_left == TOG_W'(1)) begin
              nxt.blink_active = 1'b0;
              nxt.leds         = '0;
            end
          end
        end
        if (cur.alt_active && (alt_elapsed >= cur.alt_period)) begin
          if (!cur.alt_next_is_second) begin
            nxt.leds = {nxt.leds[2], 2'b01};
          end else begin
            nxt.leds = {nxt.leds[2], 2'b10};
          end
          nxt.alt_next_is_second = !cur.alt_next_is_second;
          nxt.last_event         = now_inc;
        end
      end
      CMD_HIT: begin
        nxt.hit_active   = 1'b1;
        nxt.hit_deadline = cur.now + duration;
        nxt.leds         = cur.leds | sel_mask;
      end
      CMD_BLINK: begin
        // ignored while a blink runs
        if (!cur.blink_active) begin
          nxt.blink_light  = light;
          nxt.blink_period = duration;
          nxt.toggles_left = {blink_count, 1'b0};
          nxt.blink_active = 1'b1;
          nxt.last_event   = cur.now;
        end
      end
      CMD_STOP_BLINK: begin
        nxt.blink_active = 1'b0;
        nxt.leds         = '0;
      end
      CMD_ALT: begin
        nxt.alt_period = duration;
        nxt.alt_active = 1'b1;
        nxt.last_event = cur.now;
      end
      CMD_STOP_ALT: begin
        nxt.alt_active = 1'b0;
        nxt.leds       = {cur.leds[2], 2'b00};
      end
      CMD_ON: begin
        nxt.leds = cur.leds | sel_mask;
      end
      CMD_OFF: begin
        nxt.leds = cur.leds & ~sel_mask;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

>>> design/led_timed_pattern_controller_core.sv
// ----------------------------------------------------------------------------
// led_timed_pattern_controller_core
// Drives three leds from command and millisecond tick beats: hit, blink,
// alternate, on, off and stop commands.
// ----------------------------------------------------------------------------
// Every accepted input beat yields exactly one status beat carrying the
// led levels and busy flags after that beat. The state register is updated
// in the cycle a beat is accepted and also serves as the output register, so
// a new beat is taken each cycle as long as the previous status beat is
// consumed in the same cycle or the output slot is empty; the output ready
// is the only thing that holds the input back. No clearing pass after reset.
module led_timed_pattern_controller_core import ltpc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  ltpc_in_if.sink         in_ch,
  ltpc_out_if.source      out_ch
);

  ltpc_state_t state_r;
  ltpc_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_accept;
  ltpc_cmd_t   in_cmd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign in_cmd      = ltpc_cmd_t'(in_ch.cmd);

  ltpc_step u_step (
    .cur         (state_r),
    .cmd         (in_cmd),
    .light       (in_ch.light),
    .duration    (in_ch.duration),
    .blink_count (in_ch.blink_count),
    .nxt         (state_nxt)
  );

  assign out_valid_nxt = in_accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
    end
  end

  // state only moves on an accepted beat, so it doubles as the output payload
  assign out_ch.valid          = out_valid_r;
  assign out_ch.leds           = state_r.leds;
  assign out_ch.blink_busy     = state_r.blink_active;
  assign out_ch.alternate_busy = state_r.alt_active;
  assign out_ch.hit_busy       = state_r.hit_active;

`ifndef SYNTHESIS
  a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted beat produced no status beat");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(state_r))
    else $error("state changed without an accepted beat");

  a_tick_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_cmd == CMD_TICK)) |=> (state_r.now == $past(state_r.now) + 1'b1))
    else $error("tick did not advance time by one");

  a_stop_alt_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_cmd == CMD_STOP_ALT)) |=>
      (!state_r.alt_active && (state_r.leds[1:0] == 2'b00)))
    else $error("stop alternate left led1 or led2 lit");
`endif

endmodule

>>> test/ltpc_status_checker.sv
// ----------------------------------------------------------------------------
// ltpc_status_checker
// Watches both channels of the led controller, keeps its own copy of the
// timer, hit, blink and alternate state, and compares every status beat
// with the levels and busy flags that the accepted command beats call for.
// ----------------------------------------------------------------------------
module ltpc_status_checker import ltpc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ltpc_in_if          in_ch,
  ltpc_out_if         out_ch,
  output int unsigned mismatches,
  output int unsigned pending
);

  typedef struct packed {
    logic [LED_W-1:0] leds;
    logic             blink_busy;
    logic             alternate_busy;
    logic             hit_busy;
  } led_status_t;

  led_status_t        status_q[$];
  int unsigned        fail_total;
  int unsigned        status_index;

  logic [TIME_W-1:0]  ms_now;
  logic [LED_W-1:0]   led_lv;
  logic               hit_on;
  logic [TIME_W-1:0]  hit_deadline;
  logic               blink_on;
  logic [LIGHT_W-1:0] blink_led;
  logic [TIME_W-1:0]  blink_period;
  logic [TOG_W-1:0]   toggles_left;
  logic [TIME_W-1:0]  last_event_ms;
  logic               alt_on;
  logic [TIME_W-1:0]  alt_period;
  logic               alt_second;

  function automatic logic [LED_W-1:0] light_onehot(input logic [LIGHT_W-1:0] light);
    logic [LED_W-1:0] bits;
    bits = '0;
    if (light == LIGHT_LED1) bits = 3'b001;
    if (light == LIGHT_LED2) bits = 3'b010;
    if (light == LIGHT_LED3) bits = 3'b100;
    return bits;
  endfunction

  task automatic clear_state();
    ms_now        = '0;
    led_lv        = '0;
    hit_on        = 1'b0;
    hit_deadline  = '0;
    blink_on      = 1'b0;
    blink_led     = '0;
    blink_period  = '0;
    toggles_left  = '0;
    last_event_ms = '0;
    alt_on        = 1'b0;
    alt_period    = '0;
    alt_second    = 1'b0;
  endtask

  // one millisecond: expiry first, then blink, then alternate
  task automatic advance_ms();
    logic [LED_W-1:0] sel;
    ms_now = ms_now + 1'b1;
    if (hit_on && ms_now > hit_deadline) begin
      led_lv = '0;
      hit_on = 1'b0;
    end
    if (blink_on && (ms_now - last_event_ms) >= blink_period) begin
      sel = light_onehot(blink_led);
      // an out-of-range blink stays armed but never moves
      if (sel != '0) begin
        led_lv = led_lv ^ sel;
        last_event_ms = ms_now;
        if (toggles_left != '0) begin
          toggles_left = toggles_left - 1'b1;
          if (toggles_left == '0) begin
            blink_on = 1'b0;
            led_lv = '0;
          end
        end
      end
    end
    if (alt_on && (ms_now - last_event_ms) >= alt_period) begin
      if (!alt_second) begin
        led_lv = (led_lv | 3'b001) & 3'b101;
      end else begin
        led_lv = (led_lv & 3'b110) | 3'b010;
      end
      alt_second = !alt_second;
      last_event_ms = ms_now;
    end
  endtask

  task automatic apply_command(input ltpc_cmd_t cmd, input logic [LIGHT_W-1:0] light,
                               input logic [TIME_W-1:0] dur, input logic [CNT_W-1:0] cnt);
    logic [LED_W-1:0] sel;
    sel = light_onehot(light);
    case (cmd)
      CMD_TICK: begin
        advance_ms();
      end
      CMD_HIT: begin
        hit_on = 1'b1;
        hit_deadline = ms_now + dur;
        led_lv = led_lv | sel;
      end
      CMD_BLINK: begin
        if (!blink_on) begin
          blink_led = light;
          blink_period = dur;
          toggles_left = {cnt, 1'b0};
          blink_on = 1'b1;
          last_event_ms = ms_now;
        end
      end
      CMD_STOP_BLINK: begin
        blink_on = 1'b0;
        led_lv = '0;
      end
      CMD_ALT: begin
        alt_period = dur;
        alt_on = 1'b1;
        last_event_ms = ms_now;
      end
      CMD_STOP_ALT: begin
        alt_on = 1'b0;
        led_lv = led_lv & 3'b100;
      end
      CMD_ON: begin
        led_lv = led_lv | sel;
      end
      CMD_OFF: begin
        led_lv = led_lv & ~sel;
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    led_status_t got;
    led_status_t want;
    if (!rst_n) begin
      clear_state();
      status_q.delete();
      fail_total = 0;
      status_index = 0;
    end else begin
      // retire the older status beat before queueing the new one
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.leds, out_ch.blink_busy, out_ch.alternate_busy, out_ch.hit_busy};
        if (status_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("status beat %0d arrived with no command outstanding: leds=%b b=%b a=%b h=%b",
                     status_index, got.leds, got.blink_busy, got.alternate_busy,
                     got.hit_busy);
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= 10)
              $display("status beat %0d: expected leds=%b b=%b a=%b h=%b,",
                       status_index, want.leds, want.blink_busy, want.alternate_busy,
                       want.hit_busy, " got leds=%b b=%b a=%b h=%b",
                       got.leds, got.blink_busy, got.alternate_busy, got.hit_busy);
          end
        end
        status_index++;
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_command(ltpc_cmd_t'(in_ch.cmd), in_ch.light, in_ch.duration, in_ch.blink_count);
        status_q.push_back('{led_lv, blink_on, alt_on, hit_on});
      end
    end
    mismatches <= fail_total;
    pending    <= status_q.size();
  end

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for led_timed_pattern_controller_core: directed command beats,
// then random hit, blink and alternate sequences with tick runs and noise,
// under random source gaps and sink stalls; the checker judges each beat.
// ----------------------------------------------------------------------------
module tb import ltpc_pkg::*;;

  localparam int unsigned RANDOM_BEATS = 600;
  localparam int unsigned QUIET_FROM   = 520;
  localparam int unsigned STALL_LIMIT  = 1000;

  logic        clk;
  logic        rst_n;
  bit          source_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned beats_sent  = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches;
  int unsigned pending;

  ltpc_in_if  in_ch ();
  ltpc_out_if out_ch ();

  led_timed_pattern_controller_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ltpc_status_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sink side: stall bursts mixed with runs of steady ready
  initial begin
    int burst;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stalls && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        burst = $urandom_range(1, 14);
      end else begin
        out_ch.ready <= 1'b1;
        burst = $urandom_range(1, 20);
      end
      repeat (burst - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("led_timed_pattern_controller_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_beat(input ltpc_cmd_t cmd, input logic [7:0] light,
                           input logic [31:0] dur, input logic [14:0] cnt);
    int gap;
    if (source_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.light       <= light;
    in_ch.duration    <= dur;
    in_ch.blink_count <= cnt;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // unused fields carry noise so every bit toggles
  task automatic tick_run(input int n);
    repeat (n) send_beat(CMD_TICK, 8'($urandom), $urandom, 15'($urandom));
  endtask

  function automatic logic [7:0] pick_light();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom);
      1:       return 8'd0;
      default: return 8'($urandom_range(LIGHT_LED1, LIGHT_LED3));
    endcase
  endfunction

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 19))
      0:       return $urandom;
      1:       return $urandom_range(5, 12);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [31:0] pick_hold();
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 8);
    endcase
  endfunction

  function automatic logic [14:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 15'($urandom);
      1:       return 15'h7FFF;
      default: return 15'($urandom_range(0, 3));
    endcase
  endfunction

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_TICK;
    in_ch.light       <= '0;
    in_ch.duration    <= '0;
    in_ch.blink_count <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: on/off incl. numbers outside 1..3
    tick_run(1);
    send_beat(CMD_ON, LIGHT_LED1, '0, '0);
    send_beat(CMD_ON, LIGHT_LED2, '0, '0);
    send_beat(CMD_ON, LIGHT_LED3, '0, '0);
    send_beat(CMD_ON, 8'd0, '0, '0);
    send_beat(CMD_ON, 8'hFF, 32'hFFFF_FFFF, 15'h7FFF);
    send_beat(CMD_OFF, LIGHT_LED2, '0, '0);
    send_beat(CMD_OFF, 8'd200, '0, '0);
    // hit that expires, then one whose deadline wraps and expires early
    send_beat(CMD_HIT, LIGHT_LED3, 32'd2, '0);
    tick_run(3);
    send_beat(CMD_HIT, 8'hFF, 32'hFFFF_FFFF, '0);
    tick_run(1);
    // single blink with a one-tick period; a second request while busy is dropped
    send_beat(CMD_BLINK, LIGHT_LED2, 32'd1, 15'd1);
    send_beat(CMD_BLINK, LIGHT_LED1, 32'd0, 15'd5);
    tick_run(3);
    // blink on a dead light number stays busy until stopped
    send_beat(CMD_BLINK, 8'd9, 32'd0, 15'd0);
    tick_run(1);
    send_beat(CMD_STOP_BLINK, '0, '0, '0);
    send_beat(CMD_ALT, '0, 32'd0, '0);
    tick_run(2);
    send_beat(CMD_STOP_ALT, '0, '0, '0);

    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent >= QUIET_FROM) begin
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: tick_run($urandom_range(1, 8));
        3: begin
          send_beat(CMD_HIT, pick_light(), pick_hold(), 15'($urandom));
          tick_run($urandom_range(1, 10));
        end
        4, 5: begin
          send_beat(CMD_BLINK, pick_light(), pick_period(), pick_count());
          tick_run($urandom_range(2, 15));
          if ($urandom_range(0, 9) < 6)
            send_beat(CMD_STOP_BLINK, 8'($urandom), $urandom, 15'($urandom));
        end
        6: begin
          send_beat(CMD_ALT, 8'($urandom), pick_period(), 15'($urandom));
          tick_run($urandom_range(2, 12));
          if ($urandom_range(0, 1) == 0)
            send_beat(CMD_STOP_ALT, 8'($urandom), $urandom, 15'($urandom));
        end
        7: send_beat($urandom_range(0, 1) ? CMD_ON : CMD_OFF, pick_light(), $urandom,
                     15'($urandom));
        default: send_beat(ltpc_cmd_t'($urandom_range(0, 7)), 8'($urandom), $urandom,
                           15'($urandom));
      endcase
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("led_timed_pattern_controller_core: match");
    end else begin
      $display("led_timed_pattern_controller_core: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ltpc_pkg.sv
design/ltpc_if.sv
design/ltpc_step.sv
design/led_timed_pattern_controller_core.sv
test/ltpc_status_checker.sv
test/tb.sv
